@@ rtl/lpr_pkg.sv @@
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types, codes and sizes for the lossy packet relay.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;

    localparam int unsigned PORT_W      = 16;
    localparam int unsigned PCT_W       = 7;
    localparam int unsigned LIMIT_W     = 5;
    localparam int unsigned LO_W        = 64;
    localparam int unsigned HI_W        = 8;
    localparam int unsigned PAYLOAD_W   = LO_W + HI_W;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned PCT_SCALE   = 100;

    localparam logic [PCT_W-1:0]   DROP_PCT_RST  = '0;
    localparam logic [LIMIT_W-1:0] LIMIT_RST     = LIMIT_W'(16);
    localparam logic [PORT_W-1:0]  PORT_RST      = '0;

    typedef logic [PAYLOAD_W-1:0] t_payload;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DROP_PCT = 2'd0,
        CFG_LIMIT    = 2'd1,
        CFG_PORT_B   = 2'd2,
        CFG_PORT_C   = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        CMD_ARRIVAL = 1'b0,
        CMD_TICK    = 1'b1
    } t_cmd;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_SEND   = 1'b1
    } t_kind;

    typedef enum logic {
        DEST_B = 1'b0,
        DEST_C = 1'b1
    } t_dest;

    typedef enum logic [2:0] {
        ST_QUEUED_C   = 3'd0,
        ST_QUEUED_B   = 3'd1,
        ST_FIRST_DROP = 3'd2,
        ST_SECOND_DROP = 3'd3,
        ST_QUEUE_FULL = 3'd4,
        ST_UNKNOWN    = 3'd5
    } t_status;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

@@ rtl/lpr_queue.sv @@
// ----------------------------------------------------------------------------
// lpr_queue
// Circular packet queue with a programmable fill limit and registered read.
// ----------------------------------------------------------------------------
module lpr_queue
    import lpr_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [LIMIT_W-1:0] i_limit,
    input  logic               i_push,
    input  t_payload           i_push_data,
    input  logic               i_pop,
    output t_q_stat            o_stat,
    output t_payload           o_rd_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = CW + 1;
    localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    t_payload        r_mem [DEPTH];
    t_payload        r_rd_data;
    logic [AW-1:0]   r_head;
    logic [AW-1:0]   n_head;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic [SW-1:0]   tail_sum;
    logic [AW-1:0]   wr_addr;
    logic [LW-1:0]   count_x;
    logic            full;

    always_comb begin
        tail_sum = SW'(r_head) + SW'(r_count);
        if (tail_sum >= SW'(DEPTH)) begin
            wr_addr = AW'(tail_sum - SW'(DEPTH));
        end else begin
            wr_addr = AW'(tail_sum);
        end
        count_x = LW'(r_count);
        full    = (count_x >= LW'(i_limit)) || (count_x >= LW'(DEPTH));

        n_head  = r_head;
        n_count = r_count;
        if (i_pop) begin
            n_head  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
            n_count = r_count - CW'(1);
        end else if (i_push) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[wr_addr] <= i_push_data;
        end
        if (i_pop) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = full;
    assign o_rd_data    = r_rd_data;

endmodule

@@ rtl/lossy_two_way_packet_relay.sv @@
// ----------------------------------------------------------------------------
// lossy_two_way_packet_relay
// Link impairment relay between two sides with drop tests and bounded queues.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken on a rising edge with start high and
//   busy low. Command 0 is a packet arrival, command 1 a send tick.
//   Configuration: write i_cfg_data to register i_cfg_index while i_cfg_we
//   is high; only while no item is in flight.
//   Results appear for one cycle with o_strobe high, starting at the edge
//   after the one that took the item, or after the second send of a tick
//   when the item waits behind that send. An arrival gives one status
//   result; a tick gives up to two send results (toward B first), in
//   consecutive cycles, o_last marking the final one. An empty tick gives
//   no result.
//   Throughput: one item per cycle, except that a tick with both queues
//   non-empty holds the result port for both of its sends and raises busy
//   if another item is already waiting in the input register. Each
//   queue is a single-port memory: one push or one pop per cycle.
//   Reset: queues empty, registers drop_percent 0, queue_limit 16,
//   port_b 0, port_c 0. The receiver cannot stall: results are never held.
// ----------------------------------------------------------------------------
module lossy_two_way_packet_relay
    import lpr_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_command,
    input  logic [PORT_W-1:0]     i_source_port,
    input  logic [LO_W-1:0]       i_payload_lo,
    input  logic [HI_W-1:0]       i_payload_hi,
    input  logic [PCT_W-1:0]      i_random_first,
    input  logic [PCT_W-1:0]      i_random_second,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_strobe,
    output logic                  o_kind,
    output logic [2:0]            o_status,
    output logic                  o_destination,
    output logic [LO_W-1:0]       o_out_payload_lo,
    output logic [HI_W-1:0]       o_out_payload_hi,
    output logic                  o_last
);

    logic [PCT_W-1:0]   r_drop_pct;
    logic [LIMIT_W-1:0] r_limit;
    logic [PORT_W-1:0]  r_port_b;
    logic [PORT_W-1:0]  r_port_c;

    logic               r_in_vld;
    t_cmd               r_in_cmd;
    logic [PORT_W-1:0]  r_in_src;
    t_payload           r_in_data;
    logic [PCT_W-1:0]   r_in_r1;
    logic [PCT_W-1:0]   r_in_r2;

    logic               r_vld;
    t_kind              r_kind;
    t_status            r_status;
    t_dest              r_dest;
    logic               r_two;

    logic               n_vld;
    t_kind              n_kind;
    t_status            n_status;
    t_dest              n_dest;
    logic               n_two;

    logic               accept;
    logic               proc_en;
    logic               arrival;
    logic               from_b;
    logic               known;
    logic               drop2;
    t_status            arr_status;
    logic               push_b;
    logic               push_c;
    logic               pop_b;
    logic               pop_c;
    t_q_stat            b_stat;
    t_q_stat            c_stat;
    t_payload           b_rd;
    t_payload           c_rd;
    t_payload           out_data;

    assign proc_en = r_in_vld && !r_two;
    assign busy    = r_in_vld && r_two;
    assign accept  = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_pct <= DROP_PCT_RST;
            r_limit    <= LIMIT_RST;
            r_port_b   <= PORT_RST;
            r_port_c   <= PORT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DROP_PCT: r_drop_pct <= i_cfg_data[PCT_W-1:0];
                CFG_LIMIT:    r_limit    <= i_cfg_data[LIMIT_W-1:0];
                CFG_PORT_B:   r_port_b   <= i_cfg_data[PORT_W-1:0];
                CFG_PORT_C:   r_port_c   <= i_cfg_data[PORT_W-1:0];
                default:      r_limit    <= r_limit;
            endcase
        end
    end

    // hold the input register while the result port is still busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (proc_en) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_cmd  <= t_cmd'(i_command);
            r_in_src  <= i_source_port;
            r_in_data <= {i_payload_hi, i_payload_lo};
            r_in_r1   <= i_random_first;
            r_in_r2   <= i_random_second;
        end
    end

    always_comb begin
        arrival = (r_in_cmd == CMD_ARRIVAL);
        from_b  = (r_in_src == r_port_b);
        known   = from_b || (r_in_src == r_port_c);
        drop2   = (({1'b0, r_in_r2} + {1'b0, r_drop_pct}) >= (PCT_W + 1)'(PCT_SCALE));
        push_b  = 1'b0;
        push_c  = 1'b0;
        priority if (r_in_r1 <= r_drop_pct) begin
            arr_status = ST_FIRST_DROP;
        end else if (!known) begin
            arr_status = ST_UNKNOWN;
        end else if (drop2) begin
            arr_status = ST_SECOND_DROP;
        end else if (from_b) begin
            if (c_stat.full) begin
                arr_status = ST_QUEUE_FULL;
            end else begin
                arr_status = ST_QUEUED_C;
                push_c     = proc_en && arrival;
            end
        end else begin
            if (b_stat.full) begin
                arr_status = ST_QUEUE_FULL;
            end else begin
                arr_status = ST_QUEUED_B;
                push_b     = proc_en && arrival;
            end
        end
        pop_b = proc_en && !arrival && !b_stat.empty;
        pop_c = proc_en && !arrival && !c_stat.empty;
    end

    lpr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_b (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (r_limit),
        .i_push      (push_b),
        .i_push_data (r_in_data),
        .i_pop       (pop_b),
        .o_stat      (b_stat),
        .o_rd_data   (b_rd)
    );

    lpr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_c (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (r_limit),
        .i_push      (push_c),
        .i_push_data (r_in_data),
        .i_pop       (pop_c),
        .o_stat      (c_stat),
        .o_rd_data   (c_rd)
    );

    // advance a two-result tick to its C send, else build the next result
    always_comb begin
        n_vld    = 1'b0;
        n_kind   = r_kind;
        n_status = r_status;
        n_dest   = r_dest;
        n_two    = 1'b0;
        if (r_two) begin
            n_vld  = 1'b1;
            n_dest = DEST_C;
        end else if (proc_en) begin
            if (arrival) begin
                n_vld    = 1'b1;
                n_kind   = KIND_STATUS;
                n_status = arr_status;
                n_dest   = DEST_B;
            end else begin
                n_vld    = !b_stat.empty || !c_stat.empty;
                n_kind   = KIND_SEND;
                n_status = ST_QUEUED_C;
                n_dest   = b_stat.empty ? DEST_C : DEST_B;
                n_two    = !b_stat.empty && !c_stat.empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_two <= 1'b0;
        end else begin
            r_vld <= n_vld;
            r_two <= n_two;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_status <= n_status;
        r_dest   <= n_dest;
    end

    always_comb begin
        if (r_kind == KIND_SEND) begin
            out_data = (r_dest == DEST_C) ? c_rd : b_rd;
        end else begin
            out_data = '0;
        end
    end

    assign o_strobe         = r_vld;
    assign o_kind           = r_kind;
    assign o_status         = r_status;
    assign o_destination    = (r_kind == KIND_SEND) ? r_dest : DEST_B;
    assign o_out_payload_lo = out_data[LO_W-1:0];
    assign o_out_payload_hi = out_data[PAYLOAD_W-1:LO_W];
    assign o_last           = !r_two;

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> (o_strobe && o_last && o_destination == DEST_C))
        else $error("second send of a tick missing");

    a_pair_is_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_two |=> !r_two)
        else $error("send pair lasted more than two cycles");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_kind == KIND_STATUS) |->
            (o_out_payload_lo == '0 && o_out_payload_hi == '0 && o_destination == DEST_B))
        else $error("status result carries payload");

    a_one_queue_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((push_b || push_c) && (pop_b || pop_c)) && !(push_b && push_c))
        else $error("conflicting queue operations");

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lossy_two_way_packet_relay. Packet arrivals and
// send ticks go in on the command port under random sender gaps, the four
// registers are rewritten between phases while the relay is idle, and every
// status or send report is matched against a scoreboard that keeps its own
// copy of both queues and of the drop tests.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpr_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int MAX_SHOWN   = 10;

    typedef struct {
        logic            kind;
        logic [2:0]      status;
        logic            dest;
        logic [LO_W-1:0] lo;
        logic [HI_W-1:0] hi;
        logic            last;
    } relay_report_t;

    class relay_scoreboard;
        logic [PCT_W-1:0]   drop_pct;
        logic [LIMIT_W-1:0] limit;
        logic [PORT_W-1:0]  port_b;
        logic [PORT_W-1:0]  port_c;
        t_payload           toward_b [QUEUE_DEPTH_DEF];
        t_payload           toward_c [QUEUE_DEPTH_DEF];
        int unsigned        b_head, b_fill, c_head, c_fill;
        relay_report_t      owed [$];
        int unsigned        mismatches, checked, items, settings;
        int unsigned        status_hits [6];
        int unsigned        sent_b, sent_c;

        function new();
            drop_pct   = DROP_PCT_RST;
            limit      = LIMIT_RST;
            port_b     = PORT_RST;
            port_c     = PORT_RST;
            b_head     = 0;
            b_fill     = 0;
            c_head     = 0;
            c_fill     = 0;
            mismatches = 0;
            checked    = 0;
            items      = 0;
            settings   = 0;
            sent_b     = 0;
            sent_c     = 0;
            foreach (status_hits[k]) status_hits[k] = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DROP_PCT: drop_pct = val[PCT_W-1:0];
                CFG_LIMIT:    limit    = val[LIMIT_W-1:0];
                CFG_PORT_B:   port_b   = val[PORT_W-1:0];
                CFG_PORT_C:   port_c   = val[PORT_W-1:0];
                default: ;
            endcase
        endfunction

        function relay_report_t report(logic kind, logic [2:0] status, logic dest,
                                       t_payload pkt, logic last);
            relay_report_t r;
            r.kind   = kind;
            r.status = status;
            r.dest   = dest;
            r.lo     = pkt[LO_W-1:0];
            r.hi     = pkt[PAYLOAD_W-1:LO_W];
            r.last   = last;
            return r;
        endfunction

        function string show(relay_report_t r);
            return $sformatf("kind=%0d status=%0d dest=%0d payload=%h_%h last=%0d",
                             r.kind, r.status, r.dest, r.hi, r.lo, r.last);
        endfunction

        function void note_item(t_cmd cmd, logic [PORT_W-1:0] src, t_payload pkt,
                                logic [PCT_W-1:0] r1, logic [PCT_W-1:0] r2);
            t_status     st;
            int unsigned cap;
            logic        have_b, have_c;
            items++;
            cap = (limit < QUEUE_DEPTH_DEF) ? limit : QUEUE_DEPTH_DEF;
            if (cmd == CMD_ARRIVAL) begin
                if (r1 <= drop_pct) begin
                    st = ST_FIRST_DROP;
                end else if (src == port_b || src == port_c) begin
                    if (int'(r2) + int'(drop_pct) >= PCT_SCALE) begin
                        st = ST_SECOND_DROP;
                    end else if (src == port_b) begin
                        if (c_fill >= cap) begin
                            st = ST_QUEUE_FULL;
                        end else begin
                            toward_c[(c_head + c_fill) % QUEUE_DEPTH_DEF] = pkt;
                            c_fill++;
                            st = ST_QUEUED_C;
                        end
                    end else begin
                        if (b_fill >= cap) begin
                            st = ST_QUEUE_FULL;
                        end else begin
                            toward_b[(b_head + b_fill) % QUEUE_DEPTH_DEF] = pkt;
                            b_fill++;
                            st = ST_QUEUED_B;
                        end
                    end
                end else begin
                    st = ST_UNKNOWN;
                end
                status_hits[int'(st)]++;
                owed.push_back(report(KIND_STATUS, st, 1'b0, '0, 1'b1));
            end else begin
                have_b = (b_fill != 0);
                have_c = (c_fill != 0);
                if (have_b) begin
                    owed.push_back(report(KIND_SEND, '0, DEST_B, toward_b[b_head], !have_c));
                    b_head = (b_head + 1) % QUEUE_DEPTH_DEF;
                    b_fill--;
                    sent_b++;
                end
                if (have_c) begin
                    owed.push_back(report(KIND_SEND, '0, DEST_C, toward_c[c_head], 1'b1));
                    c_head = (c_head + 1) % QUEUE_DEPTH_DEF;
                    c_fill--;
                    sent_c++;
                end
            end
        endfunction

        function void check_result(relay_report_t got);
            relay_report_t want;
            checked++;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("tb: unexpected report %s", show(got));
                return;
            end
            want = owed.pop_front();
            if (got.kind !== want.kind || got.status !== want.status ||
                got.dest !== want.dest || got.lo !== want.lo ||
                got.hi !== want.hi || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("tb: report %0d expected %s", checked, show(want));
                    $display("tb: report %0d actual   %s", checked, show(got));
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_command;
    logic [PORT_W-1:0]     i_source_port;
    logic [LO_W-1:0]       i_payload_lo;
    logic [HI_W-1:0]       i_payload_hi;
    logic [PCT_W-1:0]      i_random_first;
    logic [PCT_W-1:0]      i_random_second;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_strobe;
    logic                  o_kind;
    logic [2:0]            o_status;
    logic                  o_destination;
    logic [LO_W-1:0]       o_out_payload_lo;
    logic [HI_W-1:0]       o_out_payload_hi;
    logic                  o_last;

    relay_scoreboard scoreboard;
    relay_report_t   seen_report;
    bit              steady;
    int              quiet;

    lossy_two_way_packet_relay i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_source_port    (i_source_port),
        .i_payload_lo     (i_payload_lo),
        .i_payload_hi     (i_payload_hi),
        .i_random_first   (i_random_first),
        .i_random_second  (i_random_second),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_kind           (o_kind),
        .o_status         (o_status),
        .o_destination    (o_destination),
        .o_out_payload_lo (o_out_payload_lo),
        .o_out_payload_hi (o_out_payload_hi),
        .o_last           (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            seen_report.kind   = o_kind;
            seen_report.status = o_status;
            seen_report.dest   = o_destination;
            seen_report.lo     = o_out_payload_lo;
            seen_report.hi     = o_out_payload_hi;
            seen_report.last   = o_last;
            scoreboard.check_result(seen_report);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("tb: no transfer for %0d cycles", QUIET_LIMIT);
            $display("tb: errors");
            $finish;
        end
    end

    function automatic logic [PCT_W-1:0] draw_pct();
        if ($urandom_range(9) == 0) begin
            return PCT_W'($urandom_range(127));
        end
        return PCT_W'($urandom_range(1, 100));
    endfunction

    task automatic send_item(input t_cmd cmd, input logic [PORT_W-1:0] src,
                             input t_payload pkt, input logic [PCT_W-1:0] r1,
                             input logic [PCT_W-1:0] r2);
        while (!steady && $urandom_range(99) < 36) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_command       <= cmd;
        i_source_port   <= src;
        i_payload_lo    <= pkt[LO_W-1:0];
        i_payload_hi    <= pkt[PAYLOAD_W-1:LO_W];
        i_random_first  <= r1;
        i_random_second <= r2;
        do @(posedge i_clk); while (busy);
        scoreboard.note_item(cmd, src, pkt, r1, r2);
    endtask

    // hold off until every owed report is out, then let the pipe empty
    task automatic settle();
        start <= 1'b0;
        while (scoreboard.owed.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        scoreboard.set_reg(idx, val);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] drop,
                              input logic [CFG_DATA_W-1:0] lim,
                              input logic [CFG_DATA_W-1:0] pb,
                              input logic [CFG_DATA_W-1:0] pc);
        write_reg(CFG_DROP_PCT, drop);
        write_reg(CFG_LIMIT, lim);
        write_reg(CFG_PORT_B, pb);
        write_reg(CFG_PORT_C, pc);
        i_cfg_we <= 1'b0;
        scoreboard.settings++;
    endtask

    task automatic run_phase(input int count, input int tick_pct);
        t_payload          pkt;
        logic [PORT_W-1:0] src;
        int                pick;
        repeat (count) begin
            pick = $urandom_range(99);
            pkt  = {8'($urandom), $urandom, $urandom};
            src  = PORT_W'($urandom);
            if (pick < tick_pct) begin
                send_item(CMD_TICK, src, pkt, draw_pct(), draw_pct());
            end else begin
                if (pick < 88) begin
                    src = $urandom_range(1) ? scoreboard.port_b : scoreboard.port_c;
                end
                send_item(CMD_ARRIVAL, src, pkt, draw_pct(), draw_pct());
            end
        end
    endtask

    initial begin
        scoreboard      = new();
        steady          = 1'b0;
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_command       <= CMD_ARRIVAL;
        i_source_port   <= '0;
        i_payload_lo    <= '0;
        i_payload_hi    <= '0;
        i_random_first  <= '0;
        i_random_second <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_DROP_PCT;
        i_cfg_data      <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: both ports 0, so side B wins the source match
        send_item(CMD_TICK, 16'h0000, '0, 7'd1, 7'd1);
        send_item(CMD_ARRIVAL, 16'h0000, {72{1'b1}}, 7'd1, 7'd1);
        send_item(CMD_ARRIVAL, 16'h0000, 72'h5A_FEDC_BA98_7654_3210, 7'd1, 7'd100);
        send_item(CMD_ARRIVAL, 16'hFFFF, 72'h0, 7'd100, 7'd99);
        send_item(CMD_ARRIVAL, 16'h0000, 72'h0, 7'd0, 7'd1);
        send_item(CMD_TICK, 16'h0000, '0, 7'd1, 7'd1);
        settle();

        set_config(16'd50, 16'd2, 16'h1234, 16'hFFFF);
        send_item(CMD_ARRIVAL, 16'h1234, 72'h11, 7'd50, 7'd1);
        send_item(CMD_ARRIVAL, 16'h1234, 72'h0, 7'd51, 7'd49);
        send_item(CMD_ARRIVAL, 16'h1234, 72'h22, 7'd51, 7'd50);
        send_item(CMD_ARRIVAL, 16'hFFFF, 72'hA5_0123_4567_89AB_CDEF, 7'd100, 7'd1);
        send_item(CMD_ARRIVAL, 16'hFFFF, {72{1'b1}}, 7'd127, 7'd0);
        send_item(CMD_ARRIVAL, 16'hFFFF, 72'h33, 7'd60, 7'd10);
        send_item(CMD_ARRIVAL, 16'h0000, 72'h44, 7'd60, 7'd10);
        send_item(CMD_TICK, 16'h0000, '0, 7'd1, 7'd1);
        send_item(CMD_TICK, 16'hFFFF, {72{1'b1}}, 7'd127, 7'd127);
        send_item(CMD_TICK, 16'h0000, '0, 7'd1, 7'd1);
        settle();

        set_config(16'd100, 16'd0, 16'h0000, 16'h8001);
        send_item(CMD_ARRIVAL, 16'h0000, 72'h55, 7'd100, 7'd1);
        send_item(CMD_ARRIVAL, 16'h0000, 72'h66, 7'd101, 7'd1);
        settle();

        set_config(16'd0, 16'd0, 16'h0000, 16'h8001);
        send_item(CMD_ARRIVAL, 16'h8001, 72'h77, 7'd1, 7'd1);
        settle();

        set_config(16'd0, 16'd31, 16'h7FFF, 16'h7FFF);
        send_item(CMD_ARRIVAL, 16'h7FFF, 72'h88_0000_0000_0000_0001, 7'd64, 7'd63);
        send_item(CMD_TICK, 16'h0000, '0, 7'd1, 7'd1);
        send_item(CMD_ARRIVAL, 16'h7FFF, 72'h99, 7'd127, 7'd127);
        settle();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_config(16'd0, 16'd16, 16'($urandom), 16'($urandom));
                1: set_config(16'd100, 16'd0, 16'h0000, 16'hFFFF);
                2: begin
                    steady = 1'b1;
                    set_config(16'd0, 16'd31, 16'hFFFF, 16'hFFFF);
                end
                3: set_config(16'($urandom_range(101, 127)), 16'd1,
                              16'($urandom), 16'($urandom));
                default: set_config(16'($urandom_range(0, 100)), 16'($urandom_range(0, 31)),
                                    16'($urandom), 16'($urandom));
            endcase
            run_phase(62, (phase == 2) ? 20 : $urandom_range(15, 45));
            steady = 1'b0;
            settle();
        end

        repeat (8) @(posedge i_clk);
        $display("tb: %0d items, %0d reports checked, %0d mismatches, %0d register settings",
                 scoreboard.items, scoreboard.checked, scoreboard.mismatches,
                 scoreboard.settings);
        $display("tb: queued C/B %0d/%0d, drops %0d/%0d, full %0d, unknown %0d, sent B/C %0d/%0d",
                 scoreboard.status_hits[ST_QUEUED_C], scoreboard.status_hits[ST_QUEUED_B],
                 scoreboard.status_hits[ST_FIRST_DROP], scoreboard.status_hits[ST_SECOND_DROP],
                 scoreboard.status_hits[ST_QUEUE_FULL], scoreboard.status_hits[ST_UNKNOWN],
                 scoreboard.sent_b, scoreboard.sent_c);
        if (scoreboard.mismatches == 0 && scoreboard.owed.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
